### sv/spibd_pkg.sv
`timescale 1ns / 1ps

package spibd_pkg;

    localparam logic [31:0] CLK_RESET  = 32'd48000000;

    localparam logic [7:0]  PRE_FIRST  = 8'd2;
    localparam logic [7:0]  PRE_LAST   = 8'd252;
    localparam logic [7:0]  PRE_MAX    = 8'd254;

    localparam logic [8:0]  POST_MAX   = 9'd256;
    localparam logic [8:0]  POST_LAST  = 9'd2;
    localparam logic [8:0]  POST_MIN   = 9'd1;

    localparam logic [4:0]  DIV_STEPS  = 5'd31;

    typedef struct packed {
        logic        valid;
        logic [32:0] a;
        logic [15:0] b;
        logic [8:0]  tag;
    } mul_req_t;

    typedef struct packed {
        logic        valid;
        logic [48:0] prod;
        logic [8:0]  tag;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

### sv/spibd_mul.sv
`timescale 1ns / 1ps

module spibd_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  spibd_pkg::mul_req_t req,
    output spibd_pkg::mul_rsp_t rsp
);
    import spibd_pkg::*;

    logic        valid_reg;
    logic [48:0] prod_reg;
    logic [8:0]  tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= {16'd0, req.a} * {33'd0, req.b};
        tag_reg  <= req.tag;
    end

    assign rsp.valid = valid_reg;
    assign rsp.prod  = prod_reg;
    assign rsp.tag   = tag_reg;

endmodule

### sv/spibd_div.sv
`timescale 1ns / 1ps

module spibd_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  spibd_pkg::div_req_t req,
    output spibd_pkg::div_rsp_t rsp
);
    import spibd_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] dvs_reg;

    logic [16:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[31]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_STEPS) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= 5'd0;
            rem_reg <= 16'd0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            rem_reg <= fits ? 16'(shifted - {1'b0, dvs_reg}) : shifted[15:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/spi_baud_divisor_search_core.sv
`timescale 1ns / 1ps

// SPI baud divisor search. A transfer on s_ carries a requested rate; the core
// clamps it to half the peripheral clock, searches the even prescale and then
// the post-divide, rounds to the nearer post-divide and returns one transfer on
// m_. One request at a time. The two linear searches step one candidate per
// cycle through the shared 33x16 multiplier; the quotients come from a
// restoring divider, run once or twice. s_tready is high only while the core
// is idle, also while a result still waits on m_. cfg_wen writes the
// peripheral clock (reset 48 MHz); write it only while the core is idle.
module spi_baud_divisor_search_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,   // peripheral_clock_hz

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] requested_baud

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata      // [7:0] prescale_divisor, [15:8] postdiv_field,
                                     // [47:16] achieved_baud
);
    import spibd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_POST,
        S_M1,
        S_M1W,
        S_DIV1,
        S_M2,
        S_M2W,
        S_DIV2,
        S_PICK,
        S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] clk_reg, clk_next;
    logic [31:0] baud_reg, baud_next;
    logic [32:0] bp1_reg, bp1_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [15:0] d_reg, d_next;
    logic [7:0]  pre_reg, pre_next;
    logic [8:0]  post_reg, post_next;
    logic [31:0] q1_reg, q1_next;
    logic [31:0] q2_reg, q2_next;
    logic [31:0] ach_reg, ach_next;
    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [32:0] half_sum;
    logic [31:0] half;
    logic [31:0] clamp;
    logic        pre_hit;
    logic        post_hit;
    logic [7:0]  pre_sel;
    logic [8:0]  post_m1;
    logic [31:0] e1;
    logic [31:0] e2;

    spibd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    spibd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign half_sum = {1'b0, clk_reg} + 33'd1;
    assign half     = half_sum[32:1];
    assign clamp    = (s_tdata > half) ? half : s_tdata;

    assign pre_hit  = (state_reg == S_PRE) && mul_rsp.valid &&
                      ({16'd0, clk_reg} < {mul_rsp.prod[39:0], 8'd0});
    assign post_hit = (state_reg == S_POST) && mul_rsp.valid &&
                      ({17'd0, clk_reg} >= mul_rsp.prod);
    assign pre_sel  = pre_hit ? mul_rsp.tag[7:0] : PRE_MAX;
    assign post_m1  = post_reg - 9'd1;

    assign e1 = (q1_reg >= baud_reg) ? (q1_reg - baud_reg) : (baud_reg - q1_reg);
    assign e2 = (q2_reg >= baud_reg) ? (q2_reg - baud_reg) : (baud_reg - q2_reg);

    always_comb begin
        mul_req.valid = 1'b0;
        mul_req.a     = 33'd0;
        mul_req.b     = 16'd0;
        mul_req.tag   = 9'd0;
        case (state_reg)
            S_PRE: begin
                mul_req.valid = (cnt_reg <= {1'b0, PRE_LAST}) && !pre_hit;
                mul_req.a     = {1'b0, baud_reg};
                mul_req.b     = {7'd0, cnt_reg} + 16'd2;
                mul_req.tag   = cnt_reg;
            end
            S_POST: begin
                mul_req.valid = (cnt_reg >= POST_LAST) && !post_hit;
                mul_req.a     = bp1_reg;
                mul_req.b     = d_reg;
                mul_req.tag   = cnt_reg;
            end
            S_M1: begin
                mul_req.valid = 1'b1;
                mul_req.a     = {25'd0, pre_reg};
                mul_req.b     = {7'd0, post_reg};
            end
            S_M2: begin
                mul_req.valid = 1'b1;
                mul_req.a     = {25'd0, pre_reg};
                mul_req.b     = {7'd0, post_m1};
            end
            default: begin
            end
        endcase
    end

    assign div_req.start    = (state_reg == S_M1W) || (state_reg == S_M2W);
    assign div_req.dividend = clk_reg;
    assign div_req.divisor  = mul_rsp.prod[15:0];

    always_comb begin
        state_next   = state_reg;
        clk_next     = cfg_wen ? cfg_wdata : clk_reg;
        baud_next    = baud_reg;
        bp1_next     = bp1_reg;
        cnt_next     = cnt_reg;
        d_next       = d_reg;
        pre_next     = pre_reg;
        post_next    = post_reg;
        q1_next      = q1_reg;
        q2_next      = q2_reg;
        ach_next     = ach_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    baud_next  = clamp;
                    bp1_next   = {1'b0, clamp} + 33'd1;
                    cnt_next   = {1'b0, PRE_FIRST};
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                if (pre_hit || (mul_rsp.valid && mul_rsp.tag == {1'b0, PRE_LAST})) begin
                    pre_next   = pre_sel;
                    cnt_next   = POST_MAX;
                    d_next     = {pre_sel, 8'd0} - {8'd0, pre_sel};
                    state_next = S_POST;
                end else if (mul_req.valid) begin
                    cnt_next = cnt_reg + 9'd2;
                end
            end
            S_POST: begin
                if (post_hit) begin
                    post_next  = mul_rsp.tag;
                    state_next = S_M1;
                end else if (mul_rsp.valid && mul_rsp.tag == POST_LAST) begin
                    post_next  = POST_MIN;
                    state_next = S_M1;
                end else if (mul_req.valid) begin
                    cnt_next = cnt_reg - 9'd1;
                    d_next   = d_reg - {8'd0, pre_reg};
                end
            end
            S_M1: begin
                state_next = S_M1W;
            end
            S_M1W: begin
                state_next = S_DIV1;
            end
            S_DIV1: begin
                if (div_rsp.done) begin
                    q1_next = div_rsp.quotient;
                    if (post_reg > POST_MIN) begin
                        state_next = S_M2;
                    end else begin
                        ach_next   = div_rsp.quotient;
                        state_next = S_OUT;
                    end
                end
            end
            S_M2: begin
                state_next = S_M2W;
            end
            S_M2W: begin
                state_next = S_DIV2;
            end
            S_DIV2: begin
                if (div_rsp.done) begin
                    q2_next    = div_rsp.quotient;
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                if (e2 < e1) begin
                    post_next = post_m1;
                    ach_next  = q2_reg;
                end else begin
                    ach_next  = q1_reg;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {ach_reg, post_m1[7:0], pre_reg};
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            clk_reg     <= CLK_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clk_reg     <= clk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        baud_reg   <= baud_next;
        bp1_reg    <= bp1_next;
        cnt_reg    <= cnt_next;
        d_reg      <= d_next;
        pre_reg    <= pre_next;
        post_reg   <= post_next;
        q1_reg     <= q1_next;
        q2_reg     <= q2_next;
        ach_reg    <= ach_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_pre_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PRE && mul_rsp.valid) |->
            (!mul_rsp.tag[0] && mul_rsp.tag <= {1'b0, PRE_LAST}))
        else $error("prescale candidate out of range");

    a_pre_even: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POST) |-> (!pre_reg[0] && pre_reg >= PRE_FIRST))
        else $error("prescale not even");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("divider done outside a divide step");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!m_valid_reg || m_tready)) |=>
            (m_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import spibd_pkg::*;

    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned SEGMENTS    = 4;
    localparam int unsigned SEG_ITEMS   = 52;

    typedef struct packed {
        logic [7:0]  prescale;
        logic [7:0]  postdiv_field;
        logic [31:0] achieved;
    } divisor_result_t;

    class DivisorScoreboard;
        divisor_result_t awaited[$];
        int unsigned     mismatches;

        function divisor_result_t compute_divisors(logic [31:0] clk_hz, logic [31:0] req);
            divisor_result_t  r;
            logic [32:0]      half;
            longint unsigned  clk64, rate64, pre, post, q_hi, q_lo, e_hi, e_lo;
            clk64 = clk_hz;
            half = ({1'b0, clk_hz} + 33'd1) >> 1;
            rate64 = ({1'b0, req} > half) ? half : req;
            pre = PRE_FIRST;
            while (pre < PRE_MAX && clk64 >= (pre + 2) * 256 * rate64)
                pre += 2;
            post = POST_MAX;
            while (post > 1 && clk64 / (pre * (post - 1)) <= rate64)
                post--;
            if (post > 1) begin
                q_hi = clk64 / (pre * post);
                q_lo = clk64 / (pre * (post - 1));
                e_hi = (q_hi >= rate64) ? q_hi - rate64 : rate64 - q_hi;
                e_lo = (q_lo >= rate64) ? q_lo - rate64 : rate64 - q_lo;
                // tie keeps the larger post-divide
                if (e_lo < e_hi)
                    post--;
            end
            r.prescale      = pre[7:0];
            r.postdiv_field = 8'(post - 1);
            r.achieved      = 32'(clk64 / (pre * post));
            return r;
        endfunction

        function void note_request(logic [31:0] clk_hz, logic [31:0] req);
            awaited.push_back(compute_divisors(clk_hz, req));
        endfunction

        function void check_result(logic [47:0] data);
            divisor_result_t want;
            if (awaited.size() == 0) begin
                $error("unexpected result transfer %h", data);
                mismatches++;
            end else begin
                want = awaited.pop_front();
                if (data[7:0] !== want.prescale) begin
                    $error("prescale_divisor: expected %0d, actual %0d",
                           want.prescale, data[7:0]);
                    mismatches++;
                end
                if (data[15:8] !== want.postdiv_field) begin
                    $error("postdiv_field: expected %0d, actual %0d",
                           want.postdiv_field, data[15:8]);
                    mismatches++;
                end
                if (data[47:16] !== want.achieved) begin
                    $error("achieved_baud: expected %0d, actual %0d",
                           want.achieved, data[47:16]);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wen;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    DivisorScoreboard sb = new;
    logic [31:0]      periph_clk;
    int unsigned      send_idle_pct;
    int unsigned      stall_pct;
    int unsigned      quiet_cycles;

    spi_baud_divisor_search_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (s_tvalid && s_tready)
                sb.note_request(periph_clk, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= stall_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input logic [31:0] baud);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= baud;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_clock(input logic [31:0] hz);
        wait_drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= hz;
        @(posedge aclk);
        cfg_wen    <= 1'b0;
        periph_clk  = hz;
    endtask

    function automatic logic [31:0] pick_clock();
        logic [31:0] hz;
        case ($urandom_range(7))
            0: hz = 32'hFFFF_FFFF;
            1: hz = 32'd0;
            2: hz = $urandom_range(1, 16);
            3: hz = CLK_RESET;
            4: hz = $urandom;
            5: hz = $urandom_range(1000000, 200000000);
            6: hz = 32'd125000000;
            default: hz = $urandom_range(17, 65535);
        endcase
        return hz;
    endfunction

    function automatic logic [31:0] pick_baud();
        logic [31:0] baud;
        logic [31:0] p;
        logic [31:0] d;
        p = 2 * $urandom_range(1, 127);
        d = $urandom_range(1, 256);
        case ($urandom_range(9))
            0: baud = $urandom;
            1: baud = 32'd0;
            2: baud = 32'hFFFF_FFFF;
            3: baud = $urandom_range(0, 1000);
            4, 5, 6: baud = periph_clk / (p * d) + $urandom_range(0, 2) - 1;
            7, 8: baud = (periph_clk >> $urandom_range(0, 31)) ^ ($urandom & 32'hFF);
            default: baud = (periph_clk >> 1) + $urandom_range(0, 2) - 1;
        endcase
        return baud;
    endfunction

    initial begin
        logic [31:0] at_reset_clock[] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd24000000,
                                          32'd24000001, 32'd23999999, 32'd738, 32'd737,
                                          32'd12000000, 32'd1000000, 32'd16000000};
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= 32'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 32'd0;
        periph_clk    = CLK_RESET;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (at_reset_clock[i])
            send_request(at_reset_clock[i]);

        // clock at maximum: half-clock limit must not wrap
        write_clock(32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF);
        send_request(32'h8000_0000);
        send_request(32'h7FFF_FFFF);
        send_request(32'd1);
        write_clock(32'd0);
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        write_clock(32'd1);
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'd2);
        write_clock(CLK_RESET);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 22;
                    stall_pct     = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    stall_pct     = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                write_clock(pick_clock());
                repeat (SEG_ITEMS) begin
                    send_request(pick_baud());
                    if ($urandom_range(49) == 0)
                        wait_drain();
                end
            end
        end

        wait_drain();
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.pending() != 0)
                $error("%0d results never arrived", sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
